// File: hw/rtl/camt_pkg.sv
package camt_pkg;

    localparam int REQ_W = 2;
    localparam int IDX_W = 6;
    localparam int ACT_W = 7;
    localparam int OUT_W = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_INC   = 2'd0,
        REQ_DEC   = 2'd1,
        REQ_CLR   = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_WAIT
    } t_state;

endpackage

// File: hw/rtl/counter_array_max_tracker.sv
// An ordinary request reads its counter, then does a read-modify-write; the input
// stalls until the result is registered, so a new item is not taken before then.
// When the sole holder of the maximum moves down, a rescan walks the counter
// memory through its single read port before the result is registered and the
// next item is taken. A full output register stalls the input.
// Sync active-low reset clears control state and entry valid bits; counters read 0.
module counter_array_max_tracker #(
    parameter int NUM_OBJECTS = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [camt_pkg::ACT_W-1:0]       i_cfg_data,
    // request channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [camt_pkg::REQ_W-1:0]       i_req_type,
    input  logic [camt_pkg::IDX_W-1:0]       i_object_index,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [camt_pkg::OUT_W-1:0] o_object_count,
    output logic signed [camt_pkg::OUT_W-1:0] o_max_count,
    output logic [camt_pkg::ACT_W-1:0]       o_num_at_max,
    output logic                             o_bad_index
);
    import camt_pkg::*;

    // address width of the counter memory, holder / scan counter width
    localparam int AW = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam int HW = $clog2(NUM_OBJECTS + 1);

    // saturation limits of a COUNT_WIDTH-bit two's complement counter
    localparam logic signed [COUNT_WIDTH-1:0] CNT_HI = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_LO = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    // counter memory; entries not valid read as zero
    logic signed [COUNT_WIDTH-1:0] r_mem [NUM_OBJECTS];
    logic [NUM_OBJECTS-1:0]        r_vld;
    logic signed [COUNT_WIDTH-1:0] r_rdata;
    logic                          r_rvld;

    t_state r_state, n_state;

    // request latched at accept
    t_req          r_op;
    logic [AW-1:0] r_idx;
    logic          r_bad;

    // tracking state
    logic [HW-1:0]                 r_active;
    logic signed [COUNT_WIDTH-1:0] r_max, n_max;
    logic [HW-1:0]                 r_hold, n_hold;
    logic signed [COUNT_WIDTH-1:0] r_shown, n_shown;

    // rescan sequencer
    logic [HW-1:0] r_scan;
    logic          r_cvld;
    logic          r_first;

    // output register
    logic                          r_ovld;
    logic signed [OUT_W-1:0]       r_ocount;
    logic signed [OUT_W-1:0]       r_omax;
    logic [ACT_W-1:0]              r_onum;
    logic                          r_obad;

    // control decode
    logic          accept;
    logic          out_free;
    logic          fin;
    logic          scan_issue;
    logic          scan_done;
    logic          need_scan;
    logic          mem_we;
    logic [AW-1:0] rd_addr;

    // datapath values
    logic signed [COUNT_WIDTH-1:0] old_val;
    logic signed [COUNT_WIDTH-1:0] new_val;
    logic signed [COUNT_WIDTH-1:0] scan_val;
    logic [HW-1:0]                 cfg_act;
    logic signed [31:0]            ext_shown;
    logic signed [31:0]            ext_max;
    logic [31:0]                   ext_hold;
    logic [31:0]                   idx_ext;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ovld || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);

    // scan walks read addresses 0..active-1; compares follow in the cycle after each read
    assign scan_issue = (32'(r_scan) < 32'(r_active));
    assign scan_done  = !scan_issue && !r_cvld;

    // request index zero-extended to 32 bits
    assign idx_ext = 32'(i_object_index);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (need_scan) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = out_free ? ST_IDLE : ST_WAIT;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = out_free ? ST_IDLE : ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        fin     = 1'b0;
        mem_we  = 1'b0;
        rd_addr = idx_ext[AW-1:0];
        unique case (r_state)
            ST_IDLE: rd_addr = idx_ext[AW-1:0];
            ST_MOD: begin
                mem_we = !r_bad;
                fin    = !need_scan;
            end
            ST_SCAN: begin
                rd_addr = r_scan[AW-1:0];
                fin     = scan_done;
            end
            ST_WAIT: fin = 1'b1;
            default: fin = 1'b0;
        endcase
    end

    // counter update and incremental maximum tracking
    always_comb begin
        old_val   = r_rvld ? r_rdata : '0;
        scan_val  = r_rvld ? r_rdata : '0;
        new_val   = old_val;
        n_max     = r_max;
        n_hold    = r_hold;
        n_shown   = r_shown;
        need_scan = 1'b0;
        case (r_op)
            REQ_INC: if (old_val != CNT_HI) new_val = old_val + 1'b1;
            REQ_DEC: if (old_val != CNT_LO) new_val = old_val - 1'b1;
            REQ_CLR: new_val = '0;
            default: new_val = old_val;
        endcase
        if (r_state == ST_MOD) begin
            n_shown = r_bad ? '0 : new_val;
            if (!r_bad && (new_val != old_val)) begin
                if (new_val > r_max) begin
                    n_max  = new_val;
                    n_hold = HW'(1);
                end else if (new_val == r_max) begin
                    n_hold = r_hold + 1'b1;
                end else if (old_val == r_max) begin
                    // a holder leaves the maximum; the last one forces a rescan
                    if (r_hold == HW'(1)) begin
                        need_scan = 1'b1;
                    end else begin
                        n_hold = r_hold - 1'b1;
                    end
                end
            end
        end else if ((r_state == ST_SCAN) && r_cvld) begin
            if (r_first || (scan_val > r_max)) begin
                n_max  = scan_val;
                n_hold = HW'(1);
            end else if (scan_val == r_max) begin
                n_hold = r_hold + 1'b1;
            end
        end
    end

    // configured object count, clamped to 1..NUM_OBJECTS
    always_comb begin
        cfg_act = HW'(i_cfg_data);
        if (i_cfg_data == '0) begin
            cfg_act = HW'(1);
        end else if (32'(i_cfg_data) > NUM_OBJECTS) begin
            cfg_act = HW'(NUM_OBJECTS);
        end
    end

    // result fields carry the low bits of the extended values; counts are sign-extended, the holder count zero-extended
    assign ext_shown = 32'(n_shown);
    assign ext_max   = 32'(n_max);
    assign ext_hold  = 32'(n_hold);

    // counter memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= new_val;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // control and tracking registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_vld    <= '0;
            r_rvld   <= 1'b0;
            r_active <= HW'(NUM_OBJECTS);
            r_max    <= '0;
            r_hold   <= HW'(NUM_OBJECTS);
            r_cvld   <= 1'b0;
            r_first  <= 1'b0;
            r_scan   <= '0;
            r_ovld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rvld  <= r_vld[rd_addr];
            r_shown <= n_shown;

            // writing the register clears every counter
            if (i_cfg_we) begin
                r_active <= cfg_act;
                r_vld    <= '0;
                r_max    <= '0;
                r_hold   <= cfg_act;
            end else begin
                r_max  <= n_max;
                r_hold <= n_hold;
                if (mem_we) begin
                    r_vld[r_idx] <= 1'b1;
                end
            end

            if (accept) begin
                r_op  <= t_req'(i_req_type);
                r_idx <= idx_ext[AW-1:0];
                r_bad <= (idx_ext >= 32'(r_active));
            end

            if ((r_state == ST_MOD) && need_scan) begin
                r_scan  <= '0;
                r_cvld  <= 1'b0;
                r_first <= 1'b1;
            end else if (r_state == ST_SCAN) begin
                r_cvld <= scan_issue;
                if (scan_issue) begin
                    r_scan <= r_scan + 1'b1;
                end
                if (r_cvld) begin
                    r_first <= 1'b0;
                end
            end

            // output register
            if (fin && out_free) begin
                r_ovld   <= 1'b1;
                r_ocount <= ext_shown[OUT_W-1:0];
                r_omax   <= ext_max[OUT_W-1:0];
                r_onum   <= ext_hold[ACT_W-1:0];
                r_obad   <= r_bad;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ovld;
    assign o_object_count = r_ocount;
    assign o_max_count    = r_omax;
    assign o_num_at_max   = r_onum;
    assign o_bad_index    = r_obad;

endmodule
